>>> hw/rtl/ghs_pkg.sv
package ghs_pkg;

  localparam int HalfWidthDef  = 10;
  localparam int SampleBitsDef = 24;
  localparam int SampleW       = 24;
  localparam int SmoothW       = 44;
  localparam int CoefW         = 17;
  localparam int FracBits      = 16;

  typedef struct packed {
    logic shift;
    logic en;
  } cell_ctrl_t;

  // Q1.16 weights of exp(-j*j/64), indexed by |j|
  function automatic logic [CoefW-1:0] gauss_coef(input int unsigned ad);
    logic [CoefW-1:0] c;
    unique case (ad)
      0:       c = 17'd65536;
      1:       c = 17'd64520;
      2:       c = 17'd61565;
      3:       c = 17'd56939;
      4:       c = 17'd51039;
      5:       c = 17'd44344;
      6:       c = 17'd37341;
      7:       c = 17'd30477;
      8:       c = 17'd24109;
      9:       c = 17'd18485;
      10:      c = 17'd13737;
      11:      c = 17'd9894;
      12:      c = 17'd6907;
      13:      c = 17'd4674;
      14:      c = 17'd3065;
      15:      c = 17'd1948;
      default: c = 17'd1200;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/ghs_in_if.sv
interface ghs_in_if;
  logic                            valid;
  logic                            ready;
  logic [ghs_pkg::SampleW-1:0]     sample;
  logic                            final_bin;

  modport source (output valid, sample, final_bin, input ready);
  modport sink   (input valid, sample, final_bin, output ready);
endinterface

>>> hw/rtl/ghs_out_if.sv
interface ghs_out_if;
  logic                            valid;
  logic                            ready;
  logic [ghs_pkg::SmoothW-1:0]     smoothed;
  logic                            was_filtered;
  logic                            end_of_run;

  modport source (output valid, smoothed, was_filtered, end_of_run, input ready);
  modport sink   (input valid, smoothed, was_filtered, end_of_run, output ready);
endinterface

>>> hw/rtl/ghs_cell.sv
module ghs_cell #(
  parameter int DW = ghs_pkg::SampleBitsDef,
  parameter int AD = 0
) (
  input  logic                               clk_i,
  input  ghs_pkg::cell_ctrl_t                ctrl_i,
  input  logic [DW-1:0]                      tap_i,
  output logic [DW-1:0]                      tap_o,
  output logic [DW+ghs_pkg::CoefW-1:0]       prod_o
);

  localparam int PW = DW + ghs_pkg::CoefW;
  localparam logic [ghs_pkg::CoefW-1:0] Coef = ghs_pkg::gauss_coef(AD);

  logic [DW-1:0] tap_q;
  logic [PW-1:0] prod_q;

  // product of the sample entering this tap
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      tap_q <= tap_i;
    end
    if (ctrl_i.en) begin
      prod_q <= PW'(tap_i) * PW'(Coef);
    end
  end

  assign tap_o  = tap_q;
  assign prod_o = prod_q;

endmodule

>>> hw/rtl/ghs_adder_tree.sv
module ghs_adder_tree #(
  parameter int TAPS = 2 * ghs_pkg::HalfWidthDef + 1,
  parameter int PW   = ghs_pkg::SampleBitsDef + ghs_pkg::CoefW,
  parameter int AW   = PW + $clog2(TAPS)
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [PW-1:0] prod_i [TAPS],
  output logic [AW-1:0] sum_o
);

  localparam int LV = $clog2(TAPS);
  localparam int NP = 1 << LV;

  logic [AW-1:0] leaf  [NP];
  logic [AW-1:0] inner_q [NP-1];

  for (genvar i = 0; i < NP; i++) begin : g_leaf
    if (i < TAPS) begin : g_used
      assign leaf[i] = AW'(prod_i[i]);
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // heap order: node n (1-based) sums children 2n and 2n+1
  for (genvar n = 1; n < NP; n++) begin : g_node
    if (2 * n >= NP) begin : g_bottom
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          inner_q[n-1] <= leaf[2*n-NP] + leaf[2*n+1-NP];
        end
      end
    end else begin : g_upper
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          inner_q[n-1] <= inner_q[2*n-1] + inner_q[2*n];
        end
      end
    end
  end

  assign sum_o = inner_q[0];

endmodule

>>> hw/rtl/gaussian_histogram_smoother_unit.sv
// Gaussian histogram smoother: a 2*HALF_WIDTH+1 tap FIR (unnormalized Q1.16
// weights exp(-j*j/64)) over a stream of histogram bins, one bin accepted per
// cycle unless the output stalls or a flush holds the input. A row of tap
// cells shifts the bins and forms one product each; a registered adder tree
// of $clog2(2*HALF_WIDTH+1) levels sums them ahead of the output register.
// Bin i comes out when bin i+HALF_WIDTH goes in;
// the first and last HALF_WIDTH bins of each histogram pass raw (<<16) with
// was_filtered low. After a bin with final_bin set, input is held until the
// remaining bins are flushed, one per cycle unless stalled: up to
// HALF_WIDTH+1 results, end_of_run on the last. Values saturate at 2^44-1.
module gaussian_histogram_smoother_unit #(
  parameter int HALF_WIDTH  = ghs_pkg::HalfWidthDef,
  parameter int SAMPLE_BITS = ghs_pkg::SampleBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ghs_in_if.sink       in_i,
  ghs_out_if.source    out_o
);

  localparam int TAPS = 2 * HALF_WIDTH + 1;
  localparam int DW   = SAMPLE_BITS;
  localparam int PW   = DW + ghs_pkg::CoefW;
  localparam int LV   = $clog2(TAPS);
  localparam int AW   = PW + LV;
  localparam int CW   = $clog2(TAPS);
  localparam int IW   = $clog2(HALF_WIDTH + 1);
  localparam int OW   = ghs_pkg::SmoothW;
  localparam int XW   = AW + OW;

  typedef struct packed {
    logic          vld;
    logic          fin;
    logic          emit;
    logic          filt;
    logic [IW-1:0] first;
    logic [DW-1:0] raw;
  } meta_t;

  function automatic logic [OW-1:0] sat(input logic [XW-1:0] v);
    return (|v[XW-1:OW]) ? '1 : v[OW-1:0];
  endfunction

  logic [DW-1:0]       smp;
  logic [DW-1:0]       tin  [TAPS];
  logic [DW-1:0]       taps [TAPS];
  logic [PW-1:0]       prods [TAPS];
  logic [DW-1:0]       flr  [HALF_WIDTH+1];
  logic [AW-1:0]       sum;
  ghs_pkg::cell_ctrl_t cctl;

  meta_t         meta_q [LV+1];
  meta_t         meta_new;
  meta_t         tail;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] idx_q;
  logic          flush_q;
  logic          hold_q;
  logic          oval_q;
  logic [OW-1:0] sm_q;
  logic          wf_q;
  logic          eor_q;

  logic acc;
  logic en;
  logic out_free;
  logic tail_out;

  if (DW <= ghs_pkg::SampleW) begin : g_smp_cut
    assign smp = in_i.sample[DW-1:0];
  end else begin : g_smp_ext
    assign smp = {{(DW-ghs_pkg::SampleW){1'b0}}, in_i.sample};
  end

  assign tail     = meta_q[LV];
  assign out_free = !oval_q || out_o.ready;
  assign tail_out = tail.vld && (tail.emit || (tail.fin && tail.filt));
  assign en       = !flush_q && (out_free || !tail_out);
  assign acc      = in_i.valid && in_i.ready;

  assign in_i.ready = en && !hold_q;

  assign cctl.shift = acc;
  assign cctl.en    = en;

  for (genvar l = 0; l < TAPS; l++) begin : g_cell
    localparam int AD = (l < HALF_WIDTH) ? HALF_WIDTH - l : l - HALF_WIDTH;
    if (l == 0) begin : g_head
      assign tin[l] = smp;
    end else begin : g_link
      assign tin[l] = taps[l-1];
    end
    ghs_cell #(
      .DW (DW),
      .AD (AD)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cctl),
      .tap_i  (tin[l]),
      .tap_o  (taps[l]),
      .prod_o (prods[l])
    );
  end

  for (genvar k = 0; k <= HALF_WIDTH; k++) begin : g_flr
    assign flr[k] = taps[k];
  end

  ghs_adder_tree #(
    .TAPS (TAPS),
    .PW   (PW),
    .AW   (AW)
  ) u_tree (
    .clk_i  (clk_i),
    .en_i   (en),
    .prod_i (prods),
    .sum_o  (sum)
  );

  always_comb begin
    meta_new.vld   = acc;
    meta_new.fin   = in_i.final_bin;
    meta_new.emit  = !in_i.final_bin && (cnt_q >= CW'(HALF_WIDTH));
    meta_new.filt  = cnt_q >= CW'(2 * HALF_WIDTH);
    meta_new.first = (cnt_q >= CW'(HALF_WIDTH)) ? IW'(HALF_WIDTH) : IW'(cnt_q);
    meta_new.raw   = taps[HALF_WIDTH-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= LV; i++) begin
        meta_q[i] <= '0;
      end
      cnt_q   <= '0;
      idx_q   <= '0;
      flush_q <= 1'b0;
      hold_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      if (acc) begin
        if (in_i.final_bin) begin
          cnt_q  <= '0;
          hold_q <= 1'b1;
        end else if (cnt_q < CW'(2 * HALF_WIDTH)) begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (en) begin
        meta_q[0] <= meta_new;
        for (int i = 1; i <= LV; i++) begin
          meta_q[i] <= meta_q[i-1];
        end
      end
      if (out_o.ready) begin
        oval_q <= 1'b0;
      end
      if (flush_q) begin
        if (out_free) begin
          oval_q <= 1'b1;
          if (idx_q == '0) begin
            flush_q <= 1'b0;
            hold_q  <= 1'b0;
          end else begin
            idx_q <= idx_q - 1'b1;
          end
        end
      end else if (en) begin
        if (tail_out) begin
          oval_q <= 1'b1;
        end
        if (tail.vld && tail.fin) begin
          flush_q <= 1'b1;
          idx_q   <= tail.filt ? IW'(HALF_WIDTH - 1) : tail.first;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (flush_q) begin
      if (out_free) begin
        sm_q  <= sat(XW'(flr[idx_q]) << ghs_pkg::FracBits);
        wf_q  <= 1'b0;
        eor_q <= (idx_q == '0);
      end
    end else if (en && tail_out) begin
      sm_q  <= tail.filt ? sat(XW'(sum)) : sat(XW'(tail.raw) << ghs_pkg::FracBits);
      wf_q  <= tail.filt;
      eor_q <= 1'b0;
    end
  end

  assign out_o.valid        = oval_q;
  assign out_o.smoothed     = sm_q;
  assign out_o.was_filtered = wf_q;
  assign out_o.end_of_run   = eor_q;

endmodule
